>>> design/per_source_quota_admission_defines.svh
// assertion macros for the per-source quota admission block
`ifndef PER_SOURCE_QUOTA_ADMISSION_DEFINES_SVH
`define PER_SOURCE_QUOTA_ADMISSION_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PSQA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PSQA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/psqa_pkg.sv
// shared widths, codes, reset values and types of the quota admission block
package psqa_pkg;

	localparam int NUM_SOURCES_DEFAULT = 64;

	localparam int SRC_IDX_W = 6;
	localparam int SRC_SLOTS = 2 ** SRC_IDX_W;
	localparam int CNT_W     = 16;
	localparam int BYTES_W   = 32;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 88;

	localparam logic OP_SUBMIT  = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SRC_COUNT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TOT_COUNT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_SRC_BYTES = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TOT_BYTES = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BAD       = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACT_SRC   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACT_TOT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES_SRC = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES_TOT = 2'd3;

	localparam logic [CNT_W-1:0]   MAX_ACT_SRC_RST   = 16'd64;
	localparam logic [CNT_W-1:0]   MAX_ACT_TOT_RST   = 16'd256;
	localparam logic [BYTES_W-1:0] MAX_BYTES_SRC_RST = 32'd65536;
	localparam logic [BYTES_W-1:0] MAX_BYTES_TOT_RST = 32'd1048576;

	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic [BYTES_W-1:0] bytes;
	} entry_t;

endpackage

>>> design/per_source_quota_admission.sv
// per-source quota admission ledger: item and byte budgets per source and overall
//
// input beats on s_*: s_tuser is the opcode (submit or release), s_tdata the
// source slot, the replacing flag and the two byte figures. each input beat
// gives exactly one output beat on m_*: the status and the source count,
// source bytes and global bytes after the step.
// the per-source ledger sits in one synchronous memory of one entry per source.
// a beat reads its entry in the cycle it is accepted and writes it back when
// the result is loaded into the output register; a write to the slot being
// read in that same cycle is forwarded.
// throughput: one beat per cycle while the output is not stalled, set by
// the single read and write port. configuration writes on cfg_* take effect
// at once; the user must make them while idle; the block leaves it unchecked.
// reset sets the limits to their defaults, zeroes the global totals and
// marks every ledger entry as zero through per-entry valid flops; there is
// no clearing pass and input is taken right after reset.
// when m_tready is low the result holds and s_tready drops as soon as the
// beat in flight has nowhere to go.
`include "per_source_quota_admission_defines.svh"

module per_source_quota_admission import psqa_pkg::*; #(
	parameter int NUM_SOURCES = NUM_SOURCES_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// source_index, replacing, previous_bytes, request_bytes
	input  logic [S_DATA_W-1:0]  s_tdata,
	// opcode
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// status, source_count_after, source_bytes_after, total_bytes_after
	output logic [M_DATA_W-1:0]  m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int DEPTH  = (NUM_SOURCES < SRC_SLOTS) ? NUM_SOURCES : SRC_SLOTS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// input fields
	logic [SRC_IDX_W-1:0] in_src;
	logic                 in_repl;
	logic [BYTES_W-1:0]   in_prev;
	logic [BYTES_W-1:0]   in_req;
	logic                 in_fire;
	logic                 in_rng;
	logic [ADDR_W-1:0]    rd_addr;

	assign in_src  = s_tdata[SRC_IDX_W-1:0];
	assign in_repl = s_tdata[SRC_IDX_W];
	assign in_prev = s_tdata[SRC_IDX_W+1 +: BYTES_W];
	assign in_req  = s_tdata[SRC_IDX_W+1+BYTES_W +: BYTES_W];
	assign in_fire = s_tvalid && s_tready;
	assign in_rng  = 32'(in_src) < 32'(DEPTH);
	assign rd_addr = in_src[ADDR_W-1:0];

	// configuration registers
	logic [CNT_W-1:0]   max_act_src_q;
	logic [CNT_W-1:0]   max_act_tot_q;
	logic [BYTES_W-1:0] max_bytes_src_q;
	logic [BYTES_W-1:0] max_bytes_tot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_act_src_q   <= MAX_ACT_SRC_RST;
			max_act_tot_q   <= MAX_ACT_TOT_RST;
			max_bytes_src_q <= MAX_BYTES_SRC_RST;
			max_bytes_tot_q <= MAX_BYTES_TOT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_ACT_SRC:   max_act_src_q   <= cfg_data[CNT_W-1:0];
				REG_MAX_ACT_TOT:   max_act_tot_q   <= cfg_data[CNT_W-1:0];
				REG_MAX_BYTES_SRC: max_bytes_src_q <= cfg_data[BYTES_W-1:0];
				REG_MAX_BYTES_TOT: max_bytes_tot_q <= cfg_data[BYTES_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 control and payload
	logic                 valid_s1;
	logic                 op_s1;
	logic                 repl_s1;
	logic                 rng_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic [BYTES_W-1:0]   prev_s1;
	logic [BYTES_W-1:0]   req_s1;
	logic                 vld_s1;
	logic                 fwd_s1;
	entry_t               fwd_ent_s1;
	entry_t               rd_ent_s1;

	logic                 m_tvalid_q;
	logic [M_DATA_W-1:0]  m_tdata_q;
	logic [CNT_W-1:0]     total_count_q;
	logic [BYTES_W-1:0]   total_bytes_q;

	entry_t               mem [DEPTH];
	logic [DEPTH-1:0]     entry_valid_q;

	logic                 adv_s1;
	logic                 wr_en;
	entry_t               wr_ent;

	assign adv_s1   = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1      <= s_tuser;
			repl_s1    <= in_repl;
			rng_s1     <= in_rng;
			addr_s1    <= rd_addr;
			prev_s1    <= in_prev;
			req_s1     <= in_req;
			vld_s1     <= in_rng && entry_valid_q[rd_addr];
			fwd_s1     <= wr_en && (addr_s1 == rd_addr);
			fwd_ent_s1 <= wr_ent;
		end
	end

	// ledger memory, read-before-write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= wr_ent;
		end
		if (in_fire) begin
			rd_ent_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (wr_en) begin
			entry_valid_q[addr_s1] <= 1'b1;
		end
	end

	// check and update
	entry_t               cur;
	logic [BYTES_W-1:0]   src_rest;
	logic [BYTES_W-1:0]   tot_rest;
	logic [BYTES_W:0]     src_sum;
	logic [BYTES_W:0]     tot_sum;
	logic                 prev_bad;
	logic [STATUS_W-1:0]  status;
	logic                 ok;
	logic [CNT_W-1:0]     new_tc;
	logic [BYTES_W-1:0]   new_tb;
	logic [CNT_W-1:0]     out_cnt;
	logic [BYTES_W-1:0]   out_sb;
	logic [BYTES_W-1:0]   out_tb;

	always_comb begin
		cur = fwd_s1 ? fwd_ent_s1 : (vld_s1 ? rd_ent_s1 : '0);
		src_rest = cur.bytes - prev_s1;
		tot_rest = total_bytes_q - prev_s1;
		src_sum  = {1'b0, src_rest} + {1'b0, req_s1};
		tot_sum  = {1'b0, tot_rest} + {1'b0, req_s1};
		prev_bad = (prev_s1 > cur.bytes) || (prev_s1 > total_bytes_q);

		status = ST_OK;
		priority if (!rng_s1) begin
			status = ST_BAD;
		end else if (op_s1 == OP_RELEASE) begin
			if (cur.count == '0 || total_count_q == '0 || prev_bad ||
					(cur.count == CNT_W'(1) && cur.bytes != prev_s1)) begin
				status = ST_BAD;
			end
		end else if (prev_bad || (repl_s1 && cur.count == '0)) begin
			status = ST_BAD;
		end else if (!repl_s1 && cur.count >= max_act_src_q) begin
			status = ST_SRC_COUNT;
		end else if (!repl_s1 && total_count_q >= max_act_tot_q) begin
			status = ST_TOT_COUNT;
		end else if (src_sum > {1'b0, max_bytes_src_q}) begin
			status = ST_SRC_BYTES;
		end else if (tot_sum > {1'b0, max_bytes_tot_q}) begin
			status = ST_TOT_BYTES;
		end
		ok = (status == ST_OK);

		if (op_s1 == OP_RELEASE) begin
			wr_ent.count = cur.count - CNT_W'(1);
			wr_ent.bytes = src_rest;
			new_tc       = total_count_q - CNT_W'(1);
			new_tb       = tot_rest;
		end else begin
			wr_ent.count = repl_s1 ? cur.count : cur.count + CNT_W'(1);
			wr_ent.bytes = src_sum[BYTES_W-1:0];
			new_tc       = repl_s1 ? total_count_q : total_count_q + CNT_W'(1);
			new_tb       = tot_sum[BYTES_W-1:0];
		end

		out_cnt = !rng_s1 ? '0 : (ok ? wr_ent.count : cur.count);
		out_sb  = !rng_s1 ? '0 : (ok ? wr_ent.bytes : cur.bytes);
		out_tb  = ok ? new_tb : total_bytes_q;
	end

	assign wr_en = adv_s1 && ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_count_q <= '0;
			total_bytes_q <= '0;
		end else if (wr_en) begin
			total_count_q <= new_tc;
			total_bytes_q <= new_tb;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (!m_tvalid_q || m_tready) begin
			m_tvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_tdata_q <= {(M_DATA_W - STATUS_W - CNT_W - 2*BYTES_W)'(0),
				out_tb, out_sb, out_cnt, status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`PSQA_ASSERT_NOW(a_stall_blocks_input, valid_s1 && m_tvalid && !m_tready, !s_tready,
		"input taken while the beat in flight is stalled")
	`PSQA_ASSERT_NEXT(a_reject_keeps_totals, adv_s1 && !ok,
		$stable(total_count_q) && $stable(total_bytes_q),
		"rejected beat changed the global totals")
	`PSQA_ASSERT_NEXT(a_release_lowers_count, wr_en && op_s1 == OP_RELEASE,
		total_count_q == $past(total_count_q) - CNT_W'(1),
		"release did not lower the global count")
	`PSQA_ASSERT_NEXT(a_result_follows, adv_s1, m_tvalid,
		"stage advanced without loading a result")

endmodule
